// ===== hdl/tdf_pkg.sv =====
// Shared types and constants for the timed duplicate filter.
package tdf_pkg;

  localparam int TDF_ENTRIES        = 8;
  localparam int TDF_DEV_BITS       = 64;
  localparam int TDF_MEAS_BITS      = 64;
  localparam int TDF_IDX_MAX_W      = 6;   // enough for 64 entries
  localparam int TDF_TIME_W         = 48;
  localparam int TDF_WIN_US_W       = 26;  // 65535 ms * 1000 fits in 26 bits

  localparam logic [15:0]             TDF_WINDOW_MS_RESET = 16'd5000;
  localparam logic [9:0]              TDF_US_PER_MS       = 10'd1000;
  localparam logic [TDF_WIN_US_W-1:0] TDF_WINDOW_US_RESET = 26'd5000000;

  localparam logic [1:0] TDF_ACT_DUP     = 2'd0;
  localparam logic [1:0] TDF_ACT_REFRESH = 2'd1;
  localparam logic [1:0] TDF_ACT_FILL    = 2'd2;
  localparam logic [1:0] TDF_ACT_REPLACE = 2'd3;

  typedef struct packed {
    logic [63:0]           device_key;
    logic [63:0]           measure_key;
    logic [TDF_TIME_W-1:0] now_us;
  } tdf_in_word_t;

  typedef struct packed {
    logic       drop;
    logic [1:0] action;
    logic [2:0] slot_index;
  } tdf_out_word_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic                     valid;
    logic                     hit;
    logic [TDF_IDX_MAX_W-1:0] hit_idx;
    logic                     dup;
    logic                     empty;
    logic [TDF_IDX_MAX_W-1:0] free_idx;
    logic [TDF_TIME_W-1:0]    oldest_ts;
    logic [TDF_IDX_MAX_W-1:0] oldest_idx;
  } tdf_token_t;

  // Entry update broadcast to all cells
  typedef struct packed {
    logic                     wr_all;
    logic                     wr_time;
    logic [TDF_IDX_MAX_W-1:0] slot;
  } tdf_write_t;

endpackage

// ===== hdl/tdf_cell.sv =====
// One cache entry with its local compare and one stage of the search token.
module tdf_cell #(
  parameter int                              DEVICE_KEY_BITS  = tdf_pkg::TDF_DEV_BITS,
  parameter int                              MEASURE_KEY_BITS = tdf_pkg::TDF_MEAS_BITS,
  parameter logic [tdf_pkg::TDF_IDX_MAX_W-1:0] CELL_IDX       = '0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [DEVICE_KEY_BITS-1:0]          dev_key,
  input  logic [MEASURE_KEY_BITS-1:0]         meas_key,
  input  logic [tdf_pkg::TDF_TIME_W-1:0]      now_us,
  input  logic [tdf_pkg::TDF_WIN_US_W-1:0]    win_lim,
  input  tdf_pkg::tdf_write_t                 wr,
  input  logic                                wr_en,
  input  tdf_pkg::tdf_token_t                 tok_in,
  output tdf_pkg::tdf_token_t                 tok_out
);

  logic                              valid_r;
  logic [DEVICE_KEY_BITS-1:0]        dev_r;
  logic [MEASURE_KEY_BITS-1:0]       meas_r;
  logic [tdf_pkg::TDF_TIME_W-1:0]    ts_r;
  tdf_pkg::tdf_token_t               tok_r;
  tdf_pkg::tdf_token_t               tok_nxt;
  logic                              match;
  logic                              dup_here;
  logic [tdf_pkg::TDF_TIME_W-1:0]    age;
  logic                              sel;

  assign age      = now_us - ts_r;
  assign dup_here = (now_us < ts_r) ||
                    (age < {{(tdf_pkg::TDF_TIME_W-tdf_pkg::TDF_WIN_US_W){1'b0}}, win_lim});
  assign match    = valid_r && !tok_in.hit && (dev_r == dev_key) && (meas_r == meas_key);
  assign sel      = wr_en && (wr.slot == CELL_IDX);

  always_comb begin
    tok_nxt = tok_in;
    if (match) begin
      tok_nxt.hit     = 1'b1;
      tok_nxt.hit_idx = CELL_IDX;
      tok_nxt.dup     = dup_here;
    end
    if (!valid_r && !tok_in.empty) begin
      tok_nxt.empty    = 1'b1;
      tok_nxt.free_idx = CELL_IDX;
    end
    // strict less keeps the lowest index on a tie
    if (valid_r && (ts_r < tok_in.oldest_ts)) begin
      tok_nxt.oldest_ts  = ts_r;
      tok_nxt.oldest_idx = CELL_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (sel && wr.wr_all) begin
        valid_r <= 1'b1;
        dev_r   <= dev_key;
        meas_r  <= meas_key;
      end
      if (sel && (wr.wr_all || wr.wr_time)) begin
        ts_r <= now_us;
      end
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== hdl/timed_duplicate_filter.sv =====
// Top level of the timed duplicate filter: controller and the chain of entry cells.
//
//   channel   direction  ports                        word
//   in        input      in_valid, in_stall, in_data  device_key, measure_key, now_us
//   out       output     out_valid, out_stall, out_data  drop, action, slot_index
//   cfg       input      cfg_we, cfg_wdata            window_ms
//
// For each word: the accept edge registers it, then the search token walks the
// cell chain one cell per cycle, each cell registering it, then the finished token
// is latched, and last the commit updates the chosen entry and loads the output
// register, once the output register is free to take the result.
// Reset (synchronous, rst_n low) empties every entry and sets the window to 5000 ms.
// A stalled output word holds; the next input word is taken as soon as the previous
// one has committed, even while its result still waits on out_stall.
module timed_duplicate_filter #(
  parameter int ENTRIES          = tdf_pkg::TDF_ENTRIES,
  parameter int DEVICE_KEY_BITS  = tdf_pkg::TDF_DEV_BITS,
  parameter int MEASURE_KEY_BITS = tdf_pkg::TDF_MEAS_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  tdf_pkg::tdf_in_word_t  in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output tdf_pkg::tdf_out_word_t out_data,
  input  logic                   cfg_we,
  input  logic [15:0]            cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMMIT
  } state_t;

  state_t                                state_r;
  tdf_pkg::tdf_in_word_t                 item_r;
  logic                                  launch_r;
  logic [tdf_pkg::TDF_WIN_US_W-1:0]      win_lim_r;
  tdf_pkg::tdf_token_t                   res_r;
  logic                                  out_valid_r;
  tdf_pkg::tdf_out_word_t                out_data_r;

  tdf_pkg::tdf_token_t                   tok_head;
  tdf_pkg::tdf_token_t                   tok_w [ENTRIES+1];
  tdf_pkg::tdf_write_t                   wr;
  logic                                  wr_en;
  tdf_pkg::tdf_out_word_t                res_word;
  logic                                  in_acc;
  logic                                  out_free;
  logic [DEVICE_KEY_BITS-1:0]            dev_key;
  logic [MEASURE_KEY_BITS-1:0]           meas_key;

  // compare and store only the low key bits
  assign dev_key  = item_r.device_key[DEVICE_KEY_BITS-1:0];
  assign meas_key = item_r.measure_key[MEASURE_KEY_BITS-1:0];

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // token entering the head of the chain: nothing found yet, oldest time at maximum
  always_comb begin
    tok_head           = '0;
    tok_head.valid     = launch_r;
    tok_head.oldest_ts = '1;
  end

  assign tok_w[0] = tok_head;

  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      tdf_cell #(
        .DEVICE_KEY_BITS  (DEVICE_KEY_BITS),
        .MEASURE_KEY_BITS (MEASURE_KEY_BITS),
        .CELL_IDX         (tdf_pkg::TDF_IDX_MAX_W'(gi))
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .dev_key   (dev_key),
        .meas_key  (meas_key),
        .now_us    (item_r.now_us),
        .win_lim   (win_lim_r),
        .wr        (wr),
        .wr_en     (wr_en),
        .tok_in    (tok_w[gi]),
        .tok_out   (tok_w[gi+1])
      );
    end
  endgenerate

  // decide the outcome from the finished token
  always_comb begin
    wr       = '0;
    res_word = '0;
    if (res_r.hit) begin
      wr.slot             = res_r.hit_idx;
      res_word.slot_index = res_r.hit_idx[2:0];
      if (res_r.dup) begin
        res_word.drop   = 1'b1;
        res_word.action = tdf_pkg::TDF_ACT_DUP;
      end else begin
        wr.wr_time      = 1'b1;
        res_word.action = tdf_pkg::TDF_ACT_REFRESH;
      end
    end else if (res_r.empty) begin
      wr.wr_all           = 1'b1;
      wr.slot             = res_r.free_idx;
      res_word.slot_index = res_r.free_idx[2:0];
      res_word.action     = tdf_pkg::TDF_ACT_FILL;
    end else begin
      wr.wr_all           = 1'b1;
      wr.slot             = res_r.oldest_idx;
      res_word.slot_index = res_r.oldest_idx[2:0];
      res_word.action     = tdf_pkg::TDF_ACT_REPLACE;
    end
  end

  // commit only once the output register can take the result
  assign wr_en = (state_r == ST_COMMIT) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
      win_lim_r   <= tdf_pkg::TDF_WINDOW_US_RESET;
    end else begin
      launch_r <= in_acc;
      if (cfg_we) begin
        win_lim_r <= tdf_pkg::TDF_WIN_US_W'(cfg_wdata) *
                     tdf_pkg::TDF_WIN_US_W'(tdf_pkg::TDF_US_PER_MS);
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          // hold until the token leaves the tail cell
          if (tok_w[ENTRIES].valid) begin
            state_r <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
    end
    if ((state_r == ST_SEARCH) && tok_w[ENTRIES].valid) begin
      res_r <= tok_w[ENTRIES];
    end
    if (wr_en) begin
      out_data_r <= res_word;
    end
  end

endmodule
